// ----- src/heap_sort_engine_macros.svh -----
// assertion macros used by the heap sort engine sequencer
`ifndef HEAP_SORT_ENGINE_MACROS_SVH
`define HEAP_SORT_ENGINE_MACROS_SVH

// same-cycle implication, checked out of reset
`define HSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hse_pkg.sv -----
// shared constants for the heap sort engine
package hse_pkg;

  // element width
  localparam int DATA_W = 32;

  // default batch capacity
  localparam int MAX_ITEMS_DEF = 64;

endpackage

// ----- src/hse_if.sv -----
// valid/ready channel interfaces for the heap sort engine

// input word channel
interface hse_in_if;
  import hse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last_item;

  modport source(output valid, output value, output last_item, input ready);
  modport sink(input valid, input value, input last_item, output ready);
endinterface

// result word channel
interface hse_out_if;
  import hse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_result;
  logic                     overflow;

  modport source(output valid, output sorted_value, output last_result, output overflow,
                 input ready);
  modport sink(input valid, input sorted_value, input last_result, input overflow,
               output ready);
endinterface

// ----- src/heap_sort_engine.sv -----
// heap sort engine top level: batch load, in-place heapsort, ascending readout
//
//   channel  | dir | words                              | handshake
//   in_ch    | in  | value, last_item                   | valid/ready
//   out_ch   | out | sorted_value, last_result, overflow | valid/ready
//
// load takes one cycle per word; the batch closes on last_item
// sort: each sift starts with BLD_RD/BLD_LD or EXT_RD/EXT_LD, then SIFT_RD and SIFT_CMP
//   per sift level, all through the one store (one write, two registered reads)
// readout: OUT_RD, OUT_LD, OUT_WAIT per result; a stalled result holds the store idle
// input is taken only while loading; reset is synchronous, active low, empties the batch
module heap_sort_engine #(
  parameter int MAX_ITEMS = hse_pkg::MAX_ITEMS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  hse_in_if.sink    in_ch,
  hse_out_if.source out_ch
);
  import hse_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr0;
  logic [AW-1:0]            mem_raddr1;
  logic signed [DATA_W-1:0] mem_rdata0;
  logic signed [DATA_W-1:0] mem_rdata1;

  // sequencer
  hse_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_value   (in_ch.value),
    .in_last    (in_ch.last_item),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_value  (out_ch.sorted_value),
    .out_last   (out_ch.last_result),
    .out_ovf    (out_ch.overflow),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr0 (mem_raddr0),
    .mem_raddr1 (mem_raddr1),
    .mem_rdata0 (mem_rdata0),
    .mem_rdata1 (mem_rdata1)
  );

  // element store
  hse_ram #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_ram (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (mem_raddr0),
    .raddr1 (mem_raddr1),
    .rdata0 (mem_rdata0),
    .rdata1 (mem_rdata1)
  );

endmodule

// ----- src/hse_ram.sv -----
// element store: one write port, two registered read ports
module hse_ram #(
  parameter int DEPTH = hse_pkg::MAX_ITEMS_DEF,
  parameter int AW    = $clog2(hse_pkg::MAX_ITEMS_DEF)
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic signed [hse_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]                    raddr0,
  input  logic [AW-1:0]                    raddr1,
  output logic signed [hse_pkg::DATA_W-1:0] rdata0,
  output logic signed [hse_pkg::DATA_W-1:0] rdata1
);
  import hse_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ----- src/hse_ctrl.sv -----
// sequencer: load, heap build, extraction and readout over the element store
module hse_ctrl #(
  parameter int MAX_ITEMS = hse_pkg::MAX_ITEMS_DEF,
  parameter int AW        = $clog2(hse_pkg::MAX_ITEMS_DEF),
  parameter int CW        = $clog2(hse_pkg::MAX_ITEMS_DEF + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input word
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [hse_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last,
  // result word
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [hse_pkg::DATA_W-1:0] out_value,
  output logic                              out_last,
  output logic                              out_ovf,
  // store access
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic signed [hse_pkg::DATA_W-1:0] mem_wdata,
  output logic [AW-1:0]                     mem_raddr0,
  output logic [AW-1:0]                     mem_raddr1,
  input  logic signed [hse_pkg::DATA_W-1:0] mem_rdata0,
  input  logic signed [hse_pkg::DATA_W-1:0] mem_rdata1
);
  import hse_pkg::*;
  `include "heap_sort_engine_macros.svh"

  // child indexes reach 2*MAX_ITEMS
  localparam int CHW = AW + 2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BLD_RD,
    ST_BLD_LD,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_EXT_RD,
    ST_EXT_LD,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_t;

  state_t                   state_r;
  logic [CW-1:0]            count_r;
  logic                     ovf_r;
  logic [CW-1:0]            k_r;
  logic [AW-1:0]            node_r;
  logic                     extract_r;
  logic signed [DATA_W-1:0] held_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_last_r;
  logic                     out_ovf_r;

  logic                     full;
  logic                     accept;
  logic [CW-1:0]            n_new;
  logic [CW-1:0]            heap_size;
  logic [CHW-1:0]           lc;
  logic [CHW-1:0]           rc;
  logic                     lc_ok;
  logic                     rc_ok;
  logic                     l_gt;
  logic                     r_gt;
  logic                     moving;
  logic signed [DATA_W-1:0] bv_l;
  logic signed [DATA_W-1:0] bv;
  logic [CHW-1:0]           big;

  // load bookkeeping
  assign full     = (count_r == CW'(MAX_ITEMS));
  assign in_ready = (state_r == ST_LOAD);
  assign accept   = in_valid && in_ready;
  assign n_new    = full ? count_r : count_r + CW'(1);

  // sift step: pick the larger child against the sinking value
  assign heap_size = extract_r ? k_r : count_r;
  assign lc        = CHW'({node_r, 1'b1});
  assign rc        = CHW'({node_r, 1'b0}) + CHW'(2);
  assign lc_ok     = (lc < CHW'(heap_size));
  assign rc_ok     = (rc < CHW'(heap_size));
  assign l_gt      = lc_ok && (mem_rdata0 > held_r);
  assign bv_l      = l_gt ? mem_rdata0 : held_r;
  assign r_gt      = rc_ok && (mem_rdata1 > bv_l);
  assign moving    = l_gt || r_gt;
  assign big       = r_gt ? rc : lc;
  assign bv        = r_gt ? mem_rdata1 : mem_rdata0;

  // store port steering; reads and writes fall in different states
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = node_r;
    mem_wdata  = held_r;
    mem_raddr0 = lc[AW-1:0];
    mem_raddr1 = rc[AW-1:0];
    case (state_r)
      ST_LOAD: begin
        mem_we    = accept && !full;
        mem_waddr = count_r[AW-1:0];
        mem_wdata = in_value;
      end
      ST_BLD_RD: begin
        mem_raddr0 = AW'(k_r - CW'(1));
      end
      ST_SIFT_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = moving ? bv : held_r;
      end
      ST_EXT_RD: begin
        mem_raddr0 = '0;
        mem_raddr1 = k_r[AW-1:0];
      end
      ST_EXT_LD: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[AW-1:0];
        mem_wdata = mem_rdata0;
      end
      ST_OUT_RD: begin
        mem_raddr0 = k_r[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (accept) begin
            count_r <= n_new;
            if (full) begin
              ovf_r <= 1'b1;
            end
            if (in_last) begin
              if (n_new < CW'(2)) begin
                k_r     <= '0;
                state_r <= ST_OUT_RD;
              end else begin
                k_r     <= n_new >> 1;
                state_r <= ST_BLD_RD;
              end
            end
          end
        end
        ST_BLD_RD: begin
          state_r <= ST_BLD_LD;
        end
        ST_BLD_LD: begin
          held_r    <= mem_rdata0;
          node_r    <= AW'(k_r - CW'(1));
          extract_r <= 1'b0;
          state_r   <= ST_SIFT_RD;
        end
        ST_SIFT_RD: begin
          state_r <= ST_SIFT_CMP;
        end
        ST_SIFT_CMP: begin
          if (moving) begin
            node_r  <= big[AW-1:0];
            state_r <= ST_SIFT_RD;
          end else if (!extract_r) begin
            if (k_r > CW'(1)) begin
              k_r     <= k_r - CW'(1);
              state_r <= ST_BLD_RD;
            end else begin
              k_r     <= count_r - CW'(1);
              state_r <= ST_EXT_RD;
            end
          end else begin
            if (k_r == CW'(1)) begin
              k_r     <= '0;
              state_r <= ST_OUT_RD;
            end else begin
              k_r     <= k_r - CW'(1);
              state_r <= ST_EXT_RD;
            end
          end
        end
        ST_EXT_RD: begin
          state_r <= ST_EXT_LD;
        end
        ST_EXT_LD: begin
          held_r    <= mem_rdata1;
          node_r    <= '0;
          extract_r <= 1'b1;
          state_r   <= ST_SIFT_RD;
        end
        ST_OUT_RD: begin
          state_r <= ST_OUT_LD;
        end
        ST_OUT_LD: begin
          out_value_r <= mem_rdata0;
          out_last_r  <= (k_r == count_r - CW'(1));
          out_ovf_r   <= ovf_r;
          out_valid_r <= 1'b1;
          state_r     <= ST_OUT_WAIT;
        end
        ST_OUT_WAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              count_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= ST_LOAD;
            end else begin
              k_r     <= k_r + CW'(1);
              state_r <= ST_OUT_RD;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_ovf   = out_ovf_r;

  // checks
  `HSE_ASSERT_NOW(a_no_load_during_out, out_valid_r, !in_ready, "input open while result pending")
  `HSE_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(MAX_ITEMS), "element count over capacity")
  `HSE_ASSERT_NEXT(a_reopen_after_last, out_valid_r && out_ready && out_last_r, in_ready, "batch not closed after last result")
  `HSE_ASSERT_NOW(a_no_write_in_readout, out_valid_r, !mem_we, "store written during readout")

endmodule
